@@ rtl/bca_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the block chain allocator.
package bca_pkg;

    // Table geometry: the 10-bit index fields reach at most 1024 blocks
    localparam int NUM_BLOCKS  = 1024;
    localparam int INDEX_REACH = 1024;
    localparam int MEM_DEPTH   = (NUM_BLOCKS < INDEX_REACH) ? NUM_BLOCKS : INDEX_REACH;
    localparam int ADDR_W      = $clog2(MEM_DEPTH);

    // Field widths
    localparam int FUNC_W  = 3;
    localparam int IDX_W   = 10;
    localparam int CNT_W   = 11;
    localparam int ENTRY_W = 11;

    // Table entry codes; any other value is a link to the next block
    localparam logic [ENTRY_W-1:0] ENTRY_FREE = 11'h7FE;
    localparam logic [ENTRY_W-1:0] ENTRY_END  = 11'h7FF;

    // Operation codes
    localparam logic [FUNC_W-1:0] FN_START  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_APPEND = 3'd1;
    localparam logic [FUNC_W-1:0] FN_FREE   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_READ   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_FORMAT = 3'd4;

    typedef enum logic [1:0] {
        ST_OK,
        ST_NO_FREE,
        ST_RANGE,
        ST_BROKEN
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_ALLOC,
        S_LINK,
        S_APP_RD,
        S_APP_CHK,
        S_WALK_RD,
        S_WALK_CHK,
        S_READ_RD,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_ZERO,
        PTR_IDX,
        PTR_INC,
        PTR_LINK
    } ptr_op_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_FREE_PTR,
        WR_END_FOUND,
        WR_LINK_IDX
    } wr_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_LOAD
    } cnt_op_t;

    typedef enum logic [1:0] {
        RES_NONE,
        RES_FOUND,
        RES_ENTRY
    } res_sel_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic     accept;
        ptr_op_t  ptr_op;
        logic     rd_en;
        wr_op_t   wr_op;
        cnt_op_t  cnt_op;
        logic     steps_clr;
        logic     steps_inc;
        logic     found_load;
        logic     out_load;
        res_sel_t res_sel;
        status_t  out_status;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              idx_oor;
        logic              ptr_oor;
        logic              steps_full;
        logic              rd_vld;
        logic              rd_free;
        logic              rd_end;
        logic              clear_last;
    } stat_t;

    // Blocks in use for a given block count register value
    function automatic logic [CNT_W-1:0] blocks_in_use(input logic [CNT_W-1:0] count);
        logic [CNT_W-1:0] depth;
        depth = CNT_W'(MEM_DEPTH);
        return (count > depth) ? depth : count;
    endfunction

endpackage

@@ rtl/block_chain_allocator.sv @@
// Top level of the block chain allocator: controller, datapath and checks.
//
//  channel   handshake            payload
//  -------   ------------------   ----------------------------------------------
//  request   in_valid/in_stall    func, block_index
//  result    out_valid/out_stall  result_index, is_end, is_free, status, free_blocks
//  config    cfg_we               cfg_wdata (block count)
//
// Start scans upward from block 0 for the lowest free block, the table read port reading
// one entry a cycle; append adds a tail check before the scan and a link write after it.
// Free reads, then releases, each block in the chain; read reads the one entry asked for.
// Format, a configuration write and reset each run a clearing pass over all 1024 table
// entries, during which requests stall.
// A result waits in the output register; the next request is taken meanwhile and
// completes once the register is free.
module block_chain_allocator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [bca_pkg::CNT_W-1:0]   cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [bca_pkg::FUNC_W-1:0]  func,
    input  logic [bca_pkg::IDX_W-1:0]   block_index,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [bca_pkg::IDX_W-1:0]   result_index,
    output logic                        is_end,
    output logic                        is_free,
    output logic [1:0]                  status,
    output logic [bca_pkg::CNT_W-1:0]   free_blocks
);
    import bca_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    bca_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    bca_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .func         (func),
        .block_index  (block_index),
        .cmd          (cmd),
        .stat         (stat),
        .result_index (result_index),
        .is_end       (is_end),
        .is_free      (is_free),
        .status       (status),
        .free_blocks  (free_blocks)
    );

    // Never overwrite a result that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid || !out_stall))
        else $error("result register overwritten while held");

    // No free block is reported only once the scan has passed every block in use
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && cmd.out_status == ST_NO_FREE) |-> stat.ptr_oor)
        else $error("no-free status before scan end");

    // Accepting a request does not touch the table
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> (!cmd.rd_en && cmd.wr_op == WR_NONE))
        else $error("table access while accepting a request");

    // Free count never exceeds the table depth
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (free_blocks <= CNT_W'(MEM_DEPTH)))
        else $error("free count above table depth");

endmodule

@@ rtl/bca_ctrl.sv @@
// Controller state machine for the block chain allocator.
module bca_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic           in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    input  bca_pkg::stat_t stat,
    output bca_pkg::cmd_t  cmd
);
    import bca_pkg::*;

    state_t   state_reg, state_next;
    status_t  done_st_reg, done_st_next;
    res_sel_t done_sel_reg, done_sel_next;
    logic     out_valid_reg, out_valid_next;

    // State, pending-result and output-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            done_st_reg   <= ST_OK;
            done_sel_reg  <= RES_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            done_st_reg   <= done_st_next;
            done_sel_reg  <= done_sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Take a new request only when idle and no configuration write is under way
    assign in_stall  = (state_reg != S_IDLE) || cfg_we;
    assign out_valid = out_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        done_st_next   = done_st_reg;
        done_sel_next  = done_sel_reg;
        cmd            = '0;
        cmd.ptr_op     = PTR_HOLD;
        cmd.wr_op      = WR_NONE;
        cmd.cnt_op     = CNT_HOLD;
        cmd.res_sel    = done_sel_reg;
        cmd.out_status = done_st_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                // Sweep the table, one entry a cycle
                cmd.wr_op  = WR_FREE_PTR;
                cmd.ptr_op = PTR_INC;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_valid && !cfg_we)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                unique case (stat.func)
                    FN_START:
                    begin
                        cmd.ptr_op = PTR_ZERO;
                        state_next = S_SCAN;
                    end
                    FN_APPEND:
                    begin
                        if (stat.idx_oor)
                        begin
                            done_st_next  = ST_RANGE;
                            done_sel_next = RES_NONE;
                            state_next    = S_DONE;
                        end
                        else
                        begin
                            cmd.ptr_op = PTR_IDX;
                            state_next = S_APP_RD;
                        end
                    end
                    FN_FREE:
                    begin
                        if (stat.idx_oor)
                        begin
                            done_st_next  = ST_RANGE;
                            done_sel_next = RES_NONE;
                            state_next    = S_DONE;
                        end
                        else
                        begin
                            cmd.ptr_op    = PTR_IDX;
                            cmd.steps_clr = 1'b1;
                            state_next    = S_WALK_RD;
                        end
                    end
                    FN_READ:
                    begin
                        if (stat.idx_oor)
                        begin
                            done_st_next  = ST_RANGE;
                            done_sel_next = RES_NONE;
                            state_next    = S_DONE;
                        end
                        else
                        begin
                            cmd.ptr_op = PTR_IDX;
                            state_next = S_READ_RD;
                        end
                    end
                    FN_FORMAT:
                    begin
                        // Count is final now; the sweep follows the result
                        cmd.cnt_op    = CNT_LOAD;
                        done_st_next  = ST_OK;
                        done_sel_next = RES_NONE;
                        state_next    = S_DONE;
                    end
                    default:
                    begin
                        done_st_next  = ST_OK;
                        done_sel_next = RES_NONE;
                        state_next    = S_DONE;
                    end
                endcase
            end

            S_APP_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_APP_CHK;
            end

            S_APP_CHK:
            begin
                // Only a chain's tail may be extended
                if (!stat.rd_end)
                begin
                    done_st_next  = ST_BROKEN;
                    done_sel_next = RES_NONE;
                    state_next    = S_DONE;
                end
                else
                begin
                    cmd.ptr_op = PTR_ZERO;
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // Reads issue back to back; data for the previous address is checked
                if (stat.rd_vld && stat.rd_free)
                begin
                    cmd.found_load = 1'b1;
                    state_next     = S_ALLOC;
                end
                else if (stat.ptr_oor)
                begin
                    done_st_next  = ST_NO_FREE;
                    done_sel_next = RES_NONE;
                    state_next    = S_DONE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.ptr_op = PTR_INC;
                end
            end

            S_ALLOC:
            begin
                cmd.wr_op  = WR_END_FOUND;
                cmd.cnt_op = CNT_DEC;
                if (stat.func == FN_APPEND)
                begin
                    state_next = S_LINK;
                end
                else
                begin
                    done_st_next  = ST_OK;
                    done_sel_next = RES_FOUND;
                    state_next    = S_DONE;
                end
            end

            S_LINK:
            begin
                cmd.wr_op     = WR_LINK_IDX;
                done_st_next  = ST_OK;
                done_sel_next = RES_FOUND;
                state_next    = S_DONE;
            end

            S_WALK_RD:
            begin
                if (stat.ptr_oor || stat.steps_full)
                begin
                    done_st_next  = ST_BROKEN;
                    done_sel_next = RES_NONE;
                    state_next    = S_DONE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_WALK_CHK;
                end
            end

            S_WALK_CHK:
            begin
                if (stat.rd_free)
                begin
                    done_st_next  = ST_BROKEN;
                    done_sel_next = RES_NONE;
                    state_next    = S_DONE;
                end
                else
                begin
                    // Release this block, then follow its link
                    cmd.wr_op     = WR_FREE_PTR;
                    cmd.cnt_op    = CNT_INC;
                    cmd.steps_inc = 1'b1;
                    if (stat.rd_end)
                    begin
                        done_st_next  = ST_OK;
                        done_sel_next = RES_NONE;
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        cmd.ptr_op = PTR_LINK;
                        state_next = S_WALK_RD;
                    end
                end
            end

            S_READ_RD:
            begin
                cmd.rd_en     = 1'b1;
                done_st_next  = ST_OK;
                done_sel_next = RES_ENTRY;
                state_next    = S_DONE;
            end

            S_DONE:
            begin
                // Wait for the output slot, then load the result
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    if (stat.func == FN_FORMAT)
                    begin
                        cmd.ptr_op = PTR_ZERO;
                        state_next = S_CLEAR;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A configuration write reformats the table
        if (cfg_we)
        begin
            state_next = S_CLEAR;
        end
    end

    // Hold the result until it is taken
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

endmodule

@@ rtl/bca_datapath.sv @@
// Datapath for the block chain allocator: link table memory, pointers, counters and result register.
module bca_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [bca_pkg::CNT_W-1:0]    cfg_wdata,
    input  logic [bca_pkg::FUNC_W-1:0]   func,
    input  logic [bca_pkg::IDX_W-1:0]    block_index,
    input  bca_pkg::cmd_t                cmd,
    output bca_pkg::stat_t               stat,
    output logic [bca_pkg::IDX_W-1:0]    result_index,
    output logic                         is_end,
    output logic                         is_free,
    output logic [1:0]                   status,
    output logic [bca_pkg::CNT_W-1:0]    free_blocks
);
    import bca_pkg::*;

    // Link table
    logic [ENTRY_W-1:0] mem [MEM_DEPTH];

    logic [CNT_W-1:0]   block_count_reg;
    logic [CNT_W-1:0]   free_count_reg, free_count_next;
    logic [CNT_W-1:0]   ptr_reg, ptr_next;
    logic [CNT_W-1:0]   steps_reg;
    logic               rd_vld_reg;
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]   rd_addr_reg;
    logic [FUNC_W-1:0]  func_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   found_reg;

    logic [IDX_W-1:0]   result_index_reg;
    logic               is_end_reg;
    logic               is_free_reg;
    status_t            status_reg;
    logic [CNT_W-1:0]   free_blocks_reg;

    logic [CNT_W-1:0]   n_cur;
    logic               rd_free;
    logic               rd_end;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ENTRY_W-1:0] wr_data;

    assign n_cur   = blocks_in_use(block_count_reg);
    assign rd_free = (rd_data_reg == ENTRY_FREE);
    assign rd_end  = (rd_data_reg == ENTRY_END);

    // Pointer next value
    always_comb
    begin
        unique case (cmd.ptr_op)
            PTR_HOLD: ptr_next = ptr_reg;
            PTR_ZERO: ptr_next = '0;
            PTR_IDX:  ptr_next = CNT_W'(idx_reg);
            PTR_INC:  ptr_next = ptr_reg + CNT_W'(1);
            PTR_LINK: ptr_next = CNT_W'(rd_data_reg[IDX_W-1:0]);
            default:  ptr_next = ptr_reg;
        endcase
    end

    // Free count next value
    always_comb
    begin
        unique case (cmd.cnt_op)
            CNT_HOLD: free_count_next = free_count_reg;
            CNT_INC:  free_count_next = free_count_reg + CNT_W'(1);
            CNT_DEC:  free_count_next = free_count_reg - CNT_W'(1);
            CNT_LOAD: free_count_next = n_cur;
            default:  free_count_next = free_count_reg;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg <= CNT_W'(INDEX_REACH);
            free_count_reg  <= CNT_W'(MEM_DEPTH);
            ptr_reg         <= '0;
            steps_reg       <= '0;
            rd_vld_reg      <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.rd_en;
            if (cmd.steps_clr)
            begin
                steps_reg <= '0;
            end
            else if (cmd.steps_inc)
            begin
                steps_reg <= steps_reg + CNT_W'(1);
            end
            if (cfg_we)
            begin
                block_count_reg <= cfg_wdata;
                free_count_reg  <= blocks_in_use(cfg_wdata);
                ptr_reg         <= '0;
            end
            else
            begin
                free_count_reg <= free_count_next;
                ptr_reg        <= ptr_next;
            end
        end
    end

    // Request and found-block registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            func_reg <= func;
            idx_reg  <= block_index;
        end
        if (cmd.found_load)
        begin
            found_reg <= rd_addr_reg;
        end
    end

    // Write port select
    always_comb
    begin
        wr_en   = 1'b1;
        wr_addr = ptr_reg[ADDR_W-1:0];
        wr_data = ENTRY_FREE;
        unique case (cmd.wr_op)
            WR_NONE:
            begin
                wr_en = 1'b0;
            end
            WR_FREE_PTR:
            begin
                wr_addr = ptr_reg[ADDR_W-1:0];
                wr_data = ENTRY_FREE;
            end
            WR_END_FOUND:
            begin
                wr_addr = found_reg[ADDR_W-1:0];
                wr_data = ENTRY_END;
            end
            WR_LINK_IDX:
            begin
                wr_addr = idx_reg[ADDR_W-1:0];
                wr_data = ENTRY_W'(found_reg);
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Table memory: one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[ptr_reg[ADDR_W-1:0]];
            rd_addr_reg <= ptr_reg[IDX_W-1:0];
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            result_index_reg <= '0;
            is_end_reg       <= 1'b0;
            is_free_reg      <= 1'b0;
            status_reg       <= cmd.out_status;
            free_blocks_reg  <= free_count_reg;
            unique case (cmd.res_sel)
                RES_NONE:
                begin
                end
                RES_FOUND:
                begin
                    result_index_reg <= found_reg;
                end
                RES_ENTRY:
                begin
                    if (rd_free)
                    begin
                        is_free_reg <= 1'b1;
                    end
                    else if (rd_end)
                    begin
                        is_end_reg <= 1'b1;
                    end
                    else
                    begin
                        result_index_reg <= rd_data_reg[IDX_W-1:0];
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Status towards the controller
    assign stat.func       = func_reg;
    assign stat.idx_oor    = (CNT_W'(idx_reg) >= n_cur);
    assign stat.ptr_oor    = (ptr_reg >= n_cur);
    assign stat.steps_full = (steps_reg >= n_cur);
    assign stat.rd_vld     = rd_vld_reg;
    assign stat.rd_free    = rd_free;
    assign stat.rd_end     = rd_end;
    assign stat.clear_last = (ptr_reg == CNT_W'(MEM_DEPTH - 1));

    assign result_index = result_index_reg;
    assign is_end       = is_end_reg;
    assign is_free      = is_free_reg;
    assign status       = status_reg;
    assign free_blocks  = free_blocks_reg;

endmodule

@@ tb/block_chain_allocator_tb.sv @@
// Self-checking testbench for the block chain allocator: directed and random requests.
module block_chain_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bca_pkg::*;

    // Operation codes that the block treats as no operation
    localparam logic [FUNC_W-1:0] FN_NOP_FIRST = FN_FORMAT + 3'd1;
    localparam logic [FUNC_W-1:0] FN_NOP_LAST  = 3'd7;
    localparam logic [IDX_W-1:0]  LAST_BLOCK   = IDX_W'(MEM_DEPTH - 1);

    // A format's clearing pass can outlast its result, so hold off this long
    localparam int CLEAR_PASS_CYCLES = 1100;
    localparam int DRAIN_CYCLES      = 1100;
    localparam int WATCHDOG_LIMIT    = 20000;
    localparam int PRINT_LIMIT       = 40;

    typedef struct {
        logic [FUNC_W-1:0] op;
        logic [IDX_W-1:0]  blk;
    } alloc_req_t;

    typedef struct {
        int unsigned       serial;
        logic [FUNC_W-1:0] op;
        logic [IDX_W-1:0]  next_blk;
        logic              end_flag;
        logic              free_flag;
        status_t           st;
        logic [CNT_W-1:0]  free_cnt;
    } alloc_expect_t;

    logic                clk;
    logic                rst_n       = 1'b0;
    logic                cfg_we      = 1'b0;
    logic [CNT_W-1:0]    cfg_wdata   = '0;
    logic                in_valid    = 1'b0;
    logic                in_stall;
    logic [FUNC_W-1:0]   func        = FN_START;
    logic [IDX_W-1:0]    block_index = '0;
    logic                out_valid;
    logic                out_stall   = 1'b0;
    logic [IDX_W-1:0]    result_index;
    logic                is_end;
    logic                is_free;
    logic [1:0]          status;
    logic [CNT_W-1:0]    free_blocks;

    // Predicted allocator state
    logic [ENTRY_W-1:0]  link_mem [MEM_DEPTH];
    int unsigned         free_total;
    int unsigned         block_limit = 1024;

    alloc_req_t          pending_reqs[$];
    alloc_expect_t       awaited_results[$];
    alloc_req_t          next_req;
    alloc_expect_t       want;

    int unsigned         accepted_reqs = 0;
    int unsigned         checked_results = 0;
    int unsigned         size_changes = 0;
    int unsigned         mismatches = 0;
    int unsigned         status_tally [4] = '{0, 0, 0, 0};
    int unsigned         burst_left = 0;
    int unsigned         gap_left = 0;
    int unsigned         stall_mode = 0;
    int unsigned         mode_left = 0;
    int unsigned         stall_phase = 0;
    int unsigned         quiet_cycles = 0;

    block_chain_allocator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .block_index  (block_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_index (result_index),
        .is_end       (is_end),
        .is_free      (is_free),
        .status       (status),
        .free_blocks  (free_blocks)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned blocks_used();
        return (block_limit > MEM_DEPTH) ? MEM_DEPTH : block_limit;
    endfunction

    // Mark every block free and reload the free count
    function automatic void clear_links();
        int unsigned i;
        for (i = 0; i < MEM_DEPTH; i++)
            link_mem[i] = ENTRY_FREE;
        free_total = blocks_used();
    endfunction

    function automatic int unsigned lowest_free(int unsigned n);
        int unsigned i;
        for (i = 0; i < n; i++)
            if (link_mem[i] == ENTRY_FREE)
                return i;
        return n;
    endfunction

    // Apply one request to the predicted table and return the result it gives
    function automatic alloc_expect_t apply_request(logic [FUNC_W-1:0] op,
                                                    logic [IDX_W-1:0] blk,
                                                    int unsigned serial);
        alloc_expect_t r;
        int unsigned   n;
        int unsigned   f;
        int unsigned   cur;
        int unsigned   steps;
        logic [ENTRY_W-1:0] e;
        bit            walking;
        n = blocks_used();
        r.serial = serial;
        r.op = op;
        r.next_blk = '0;
        r.end_flag = 1'b0;
        r.free_flag = 1'b0;
        r.st = ST_OK;
        case (op)
            FN_START:
            begin
                f = lowest_free(n);
                if (f >= n)
                    r.st = ST_NO_FREE;
                else
                begin
                    link_mem[f] = ENTRY_END;
                    free_total--;
                    r.next_blk = IDX_W'(f);
                end
            end
            FN_APPEND:
            begin
                if (blk >= n)
                    r.st = ST_RANGE;
                else if (link_mem[blk] != ENTRY_END)
                    r.st = ST_BROKEN;
                else
                begin
                    f = lowest_free(n);
                    if (f >= n)
                        r.st = ST_NO_FREE;
                    else
                    begin
                        link_mem[blk] = ENTRY_W'(f);
                        link_mem[f] = ENTRY_END;
                        free_total--;
                        r.next_blk = IDX_W'(f);
                    end
                end
            end
            FN_FREE:
            begin
                if (blk >= n)
                    r.st = ST_RANGE;
                else
                begin
                    // walk the chain, releasing as we go; stop on any break
                    cur = blk;
                    steps = 0;
                    walking = 1'b1;
                    while (walking)
                    begin
                        if (cur >= n || steps >= n || link_mem[cur] == ENTRY_FREE)
                        begin
                            r.st = ST_BROKEN;
                            walking = 1'b0;
                        end
                        else
                        begin
                            e = link_mem[cur];
                            link_mem[cur] = ENTRY_FREE;
                            free_total++;
                            steps++;
                            if (e == ENTRY_END)
                                walking = 1'b0;
                            else
                                cur = e;
                        end
                    end
                end
            end
            FN_READ:
            begin
                if (blk >= n)
                    r.st = ST_RANGE;
                else if (link_mem[blk] == ENTRY_FREE)
                    r.free_flag = 1'b1;
                else if (link_mem[blk] == ENTRY_END)
                    r.end_flag = 1'b1;
                else
                    r.next_blk = link_mem[blk][IDX_W-1:0];
            end
            FN_FORMAT:
                clear_links();
            default: ;
        endcase
        r.free_cnt = CNT_W'(free_total);
        return r;
    endfunction

    // Pick a request that mostly follows the chains now in the table
    function automatic alloc_req_t make_request();
        alloc_req_t  rq;
        int unsigned n;
        int unsigned pick;
        int unsigned i;
        int unsigned tails[$];
        int unsigned heads[$];
        int unsigned used[$];
        bit          linked [MEM_DEPTH];
        n = blocks_used();
        for (i = 0; i < MEM_DEPTH; i++)
            linked[i] = 1'b0;
        for (i = 0; i < n; i++)
            if (link_mem[i] != ENTRY_FREE && link_mem[i] != ENTRY_END)
                linked[link_mem[i][IDX_W-1:0]] = 1'b1;
        for (i = 0; i < n; i++)
        begin
            if (link_mem[i] == ENTRY_END)
                tails.push_back(i);
            if (link_mem[i] != ENTRY_FREE)
            begin
                used.push_back(i);
                if (!linked[i])
                    heads.push_back(i);
            end
        end
        rq.blk = IDX_W'($urandom_range(0, MEM_DEPTH - 1));
        // stop picking starts once fewer than a quarter of the blocks are free
        if (free_total * 4 < n)
            pick = $urandom_range(40, 99);
        else
            pick = $urandom_range(0, 99);
        if (pick < 30)
            rq.op = FN_START;
        else if (pick < 55)
        begin
            rq.op = FN_APPEND;
            if (tails.size() != 0 && $urandom_range(0, 99) < 85)
                rq.blk = IDX_W'(tails[$urandom_range(0, tails.size() - 1)]);
        end
        else if (pick < 75)
        begin
            rq.op = FN_FREE;
            pick = $urandom_range(0, 99);
            if (heads.size() != 0 && pick < 70)
                rq.blk = IDX_W'(heads[$urandom_range(0, heads.size() - 1)]);
            else if (used.size() != 0 && pick < 85)
                rq.blk = IDX_W'(used[$urandom_range(0, used.size() - 1)]);
        end
        else if (pick < 96)
        begin
            rq.op = FN_READ;
            if (n != 0 && $urandom_range(0, 99) < 80)
                rq.blk = IDX_W'($urandom_range(0, n - 1));
        end
        else if (pick < 98)
            rq.op = FN_FORMAT;
        else
            rq.op = FUNC_W'($urandom_range(FN_NOP_FIRST, FN_NOP_LAST));
        return rq;
    endfunction

    task automatic flag_error(string msg);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task automatic check_field(alloc_expect_t w, string name,
                               logic [CNT_W-1:0] got, logic [CNT_W-1:0] exp_val);
        if (got !== exp_val)
            flag_error($sformatf("request %0d (func %0d): %s is %0h, expected %0h",
                                 w.serial, w.op, name, got, exp_val));
    endtask

    task automatic queue_request(logic [FUNC_W-1:0] op, logic [IDX_W-1:0] blk);
        alloc_req_t rq;
        rq.op = op;
        rq.blk = blk;
        pending_reqs.push_back(rq);
    endtask

    // Hold until every request is taken and every result has come back
    task automatic wait_quiet();
        @(negedge clk);
        while (pending_reqs.size() != 0 || in_valid || awaited_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_block_count(logic [CNT_W-1:0] value);
        wait_quiet();
        repeat (CLEAR_PASS_CYCLES) @(posedge clk);
        cfg_wdata <= value;
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        block_limit = value;
        clear_links();
        size_changes++;
    endtask

    // Top up the request queue one at a time so choices track the table
    task automatic run_random(int unsigned count);
        int unsigned made;
        alloc_req_t  rq;
        made = 0;
        while (made < count)
        begin
            @(negedge clk);
            if (pending_reqs.size() == 0)
            begin
                rq = make_request();
                pending_reqs.push_back(rq);
                if (rq.op <= FN_FORMAT)
                    made++;
            end
        end
    endtask

    task automatic run_phase(logic [CNT_W-1:0] value, int unsigned count);
        write_block_count(value);
        run_random(count);
    endtask

    // Request driver: bursts of requests separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                awaited_results.push_back(apply_request(func, block_index, accepted_reqs));
                accepted_reqs++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    next_req = pending_reqs.pop_front();
                    in_valid <= 1'b1;
                    func <= next_req.op;
                    block_index <= next_req.blk;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor: check against the oldest prediction, stall on its own pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                    flag_error($sformatf("result with no request outstanding (status %0d)",
                                         status));
                else
                begin
                    want = awaited_results.pop_front();
                    check_field(want, "result_index", CNT_W'(result_index),
                                CNT_W'(want.next_blk));
                    check_field(want, "is_end", CNT_W'(is_end), CNT_W'(want.end_flag));
                    check_field(want, "is_free", CNT_W'(is_free), CNT_W'(want.free_flag));
                    check_field(want, "status", CNT_W'(status), CNT_W'(want.st));
                    check_field(want, "free_blocks", free_blocks, want.free_cnt);
                    checked_results++;
                    status_tally[want.st]++;
                end
            end
            // advance the stall pattern
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            stall_phase++;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 99) < 30);
                2: out_stall <= ($urandom_range(0, 99) < 75);
                default: out_stall <= ((stall_phase % 7) < 3);
            endcase
        end
    end

    // Watchdog: drop the run if nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout: no request or result moved for %0d cycles", quiet_cycles);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Stimulus sequence
    initial
    begin
        clear_links();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // full-size table after reset: top entry, a short chain, release
        queue_request(FN_READ, LAST_BLOCK);
        queue_request(FN_START, '0);
        queue_request(FN_APPEND, 10'd0);
        queue_request(FN_READ, 10'd0);
        queue_request(FN_FREE, 10'd0);

        // three blocks: fill, overflow, range errors, broken chains
        write_block_count(11'd3);
        queue_request(FN_START, '0);
        queue_request(FN_START, LAST_BLOCK);
        queue_request(FN_APPEND, 10'd0);
        queue_request(FN_START, '0);
        queue_request(FN_APPEND, 10'd1);
        queue_request(FN_READ, 10'd0);
        queue_request(FN_READ, 10'd3);
        queue_request(FN_APPEND, LAST_BLOCK);
        queue_request(FN_FREE, 10'd0);
        queue_request(FN_FREE, 10'd0);
        queue_request(FN_APPEND, 10'd0);
        queue_request(FN_APPEND, 10'd1);
        queue_request(FN_FREE, 10'd1);
        queue_request(FN_START, '0);
        queue_request(FN_APPEND, 10'd0);
        queue_request(FN_FREE, 10'd2);
        queue_request(FN_FREE, 10'd0);
        queue_request(FN_NOP_FIRST, LAST_BLOCK);
        queue_request(FN_NOP_LAST, '0);
        queue_request(FN_FORMAT, '0);

        // zero blocks: nothing free, every index out of range
        write_block_count(11'd0);
        queue_request(FN_START, '0);
        queue_request(FN_FREE, '0);
        queue_request(FN_FORMAT, '0);
        run_random(20);

        // random phases; mostly small tables, a few large ones
        run_phase(11'd1, 60);
        run_phase(11'd2, 80);
        run_phase(11'd5, 200);
        run_phase(11'd16, 300);
        run_phase(11'd2047, 60);
        run_phase(11'd40, 300);
        run_phase(11'd1024, 60);
        run_phase(CNT_W'($urandom_range(3, 24)), 300);
        run_phase(CNT_W'($urandom_range(25, 100)), 300);
        run_phase(11'd8, 150);

        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (awaited_results.size() != 0)
            flag_error($sformatf("%0d results never arrived", awaited_results.size()));

        $display("Covered %0d requests and %0d checked results over %0d block-count settings.",
                 accepted_reqs, checked_results, size_changes);
        $display("Outcomes: ok %0d, no free block %0d, out of range %0d, broken %0d; %0d errors.",
                 status_tally[ST_OK], status_tally[ST_NO_FREE], status_tally[ST_RANGE],
                 status_tally[ST_BROKEN], mismatches);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
